// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants and types for the stable priority task queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int OCC_W   = 5;
   localparam int PRIO_W  = 8;
   localparam int WORD_W  = 32;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_POP    = 1'b1;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [WORD_W-1:0] callback;
      logic [WORD_W-1:0] argument;
   } entry_type;

   // Broadcast from the top level to every cell of the chain.
   typedef struct packed {
      logic      insert_en;
      logic      pop_en;
      entry_type new_entry;
   } cell_cmd_type;

endpackage

// ===== rtl/spq_if.sv =====
// ----------------------------------------------------------------------------
// spq_if
// Valid/ready channels for queue commands and queue responses.
// ----------------------------------------------------------------------------
interface spq_req_if;
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic [spq_pkg::PRIO_W-1:0] task_priority;
   logic [spq_pkg::WORD_W-1:0] callback_handle;
   logic [spq_pkg::WORD_W-1:0] task_argument;

   modport source (output valid, kind, task_priority, callback_handle, task_argument,
                   input ready);
   modport sink   (input valid, kind, task_priority, callback_handle, task_argument,
                   output ready);
endinterface

interface spq_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       entry_valid;
   logic [spq_pkg::PRIO_W-1:0] out_priority;
   logic [spq_pkg::WORD_W-1:0] out_callback;
   logic [spq_pkg::WORD_W-1:0] out_argument;
   logic                       dropped;
   logic [spq_pkg::OCC_W-1:0]  occupancy;

   modport source (output valid, entry_valid, out_priority, out_callback, out_argument,
                   dropped, occupancy, input ready);
   modport sink   (input valid, entry_valid, out_priority, out_callback, out_argument,
                   dropped, occupancy, output ready);
endinterface

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted shift chain: holds an entry, shifts on insert/pop.
// ----------------------------------------------------------------------------
module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_cmd_type cmd,
   input  logic                  occupied,
   input  logic                  left_take,
   input  spq_pkg::entry_type    left_entry,
   input  spq_pkg::entry_type    right_entry,
   output logic                  take,
   output spq_pkg::entry_type    entry
);

   spq_pkg::entry_type entry_ff, entry_in;

   // New entry lands before this slot when the slot is free or lower priority.
   assign take = !occupied || (entry_ff.prio < cmd.new_entry.prio);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.pop_en) begin
         entry_in = right_entry;
      end else if (cmd.insert_en) begin
         if (left_take) begin
            entry_in = left_entry;
         end else if (take) begin
            entry_in = cmd.new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/stable_priority_task_queue_top.sv =====
// ----------------------------------------------------------------------------
// stable_priority_task_queue_top
// Bounded priority queue of deferred tasks, built as a sorted shift chain.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one command per beat: kind 0 inserts {priority, callback,
//   argument}, kind 1 pops the head. Every command beat yields exactly one
//   rsp_bus beat.
//   Inserts go behind all entries of higher or equal priority, so equal
//   priorities leave in arrival order. An insert into a full queue is dropped
//   and flagged; a pop on an empty queue returns entry_valid = 0.
//   The response beat is registered and is valid in the cycle after the
//   command beat. One command per cycle while rsp_bus is not stalled. Every
//   cell compares against the new priority in parallel and shifts in the
//   same cycle that the command is taken.
//   rsp_bus has one output register; a command is taken while it is empty or
//   being drained, so a stalled receiver back-pressures req_bus after one
//   beat.
//   Reset (synchronous, active high) empties the queue and the output
//   register. Cell contents are not cleared; the entry count masks them.
// ----------------------------------------------------------------------------
module stable_priority_task_queue_top (
   input  logic       clock,
   input  logic       reset,
   spq_req_if.sink    req_bus,
   spq_rsp_if.source  rsp_bus
);

   localparam int DEPTH = spq_pkg::DEPTH;
   localparam int CNT_W = spq_pkg::CNT_W;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             entry_valid_ff, entry_valid_in;
   logic             dropped_ff, dropped_in;
   spq_pkg::entry_type out_entry_ff, out_entry_in;

   logic accept, is_pop, full, empty;
   spq_pkg::cell_cmd_type cmd;

   logic               take     [DEPTH];
   logic               occupied [DEPTH];
   spq_pkg::entry_type cell_q   [DEPTH];

   // Command side: free slot in the output register or it drains this cycle.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign is_pop        = (req_bus.kind == spq_pkg::KIND_POP);
   assign full          = (count_ff == CNT_W'(DEPTH));
   assign empty         = (count_ff == '0);

   always_comb begin
      cmd.insert_en          = accept && !is_pop && !full;
      cmd.pop_en             = accept && is_pop && !empty;
      cmd.new_entry.prio     = req_bus.task_priority;
      cmd.new_entry.callback = req_bus.callback_handle;
      cmd.new_entry.argument = req_bus.task_argument;
   end

   // Chain of cells; slot 0 is the head.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign occupied[i] = (CNT_W'(i) < count_ff);

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (occupied[i]),
         .left_take   ((i == 0) ? 1'b0 : take[(i == 0) ? 0 : i-1]),
         .left_entry  (cell_q[(i == 0) ? 0 : i-1]),
         .right_entry (cell_q[(i == DEPTH-1) ? i : i+1]),
         .take        (take[i]),
         .entry       (cell_q[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      entry_valid_in = entry_valid_ff;
      dropped_in     = dropped_ff;
      out_entry_in   = out_entry_ff;
      if (accept) begin
         rsp_valid_in   = 1'b1;
         entry_valid_in = cmd.pop_en;
         dropped_in     = !is_pop && full;
         out_entry_in   = cmd.pop_en ? cell_q[0] : '0;
      end else if (rsp_bus.ready) begin
         rsp_valid_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      entry_valid_ff <= entry_valid_in;
      dropped_ff     <= dropped_in;
      out_entry_ff   <= out_entry_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.entry_valid  = entry_valid_ff;
   assign rsp_bus.out_priority = out_entry_ff.prio;
   assign rsp_bus.out_callback = out_entry_ff.callback;
   assign rsp_bus.out_argument = out_entry_ff.argument;
   assign rsp_bus.dropped      = dropped_ff;
   // Occupancy after the item; count_ff already holds the updated value.
   assign rsp_bus.occupancy    = spq_pkg::OCC_W'(count_ff);

endmodule

// ===== rtl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Port-level assertions for the stable priority task queue.
// ----------------------------------------------------------------------------
module spq_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_entry_valid,
   input logic                       rsp_dropped,
   input logic [spq_pkg::OCC_W-1:0]  rsp_occupancy
);

   // Response beat stays up until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat withdrawn before taken");

   // A beat is either a popped entry or a refused insert, never both.
   a_pop_not_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_entry_valid && rsp_dropped))
      else $error("popped entry flagged as dropped");

   // Drops only happen at full occupancy.
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> rsp_occupancy == spq_pkg::OCC_W'(spq_pkg::DEPTH))
      else $error("insert dropped while queue not full");

   // A successful pop leaves at least one free slot.
   a_pop_room: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_valid |->
         rsp_occupancy < spq_pkg::OCC_W'(spq_pkg::DEPTH))
      else $error("pop reports full queue afterwards");

endmodule

bind stable_priority_task_queue_top spq_checker u_spq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_entry_valid (rsp_bus.entry_valid),
   .rsp_dropped     (rsp_bus.dropped),
   .rsp_occupancy   (rsp_bus.occupancy)
);
